>>> design/tblpm_pkg.sv
`default_nettype none

package tblpm_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK0_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK1_COUNT = 1'b1;

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// one stored route entry
	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [7:0]  port;
	} route_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

endpackage

`default_nettype wire

>>> design/tblpm_if.sv
`default_nettype none

// request channel
interface tblpm_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic        bank;
	logic [9:0]  entry_index;
	logic [31:0] entry_prefix;
	logic [31:0] entry_mask;
	logic [31:0] entry_next_hop;
	logic [7:0]  entry_port;
	logic [31:0] dest_addr;

	modport source (
		output valid, operation, bank, entry_index, entry_prefix, entry_mask,
			entry_next_hop, entry_port, dest_addr,
		input  ready
	);
	modport sink (
		input  valid, operation, bank, entry_index, entry_prefix, entry_mask,
			entry_next_hop, entry_port, dest_addr,
		output ready
	);
endinterface

// response channel
interface tblpm_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] next_hop_out;
	logic [7:0]  port_out;
	logic [31:0] matched_mask;
	logic        matched_bank;
	logic [9:0]  matched_index;

	modport source (
		output valid, found, next_hop_out, port_out, matched_mask, matched_bank,
			matched_index,
		input  ready
	);
	modport sink (
		input  valid, found, next_hop_out, port_out, matched_mask, matched_bank,
			matched_index,
		output ready
	);
endinterface

`default_nettype wire

>>> design/two_bank_longest_prefix_match.sv
// write transaction: entry stored on accept, result loaded in ST_LOAD once output is free
// lookup transaction: ST_SCAN reads bank0_count + bank1_count entries before ST_LOAD
//   (counts capped at bank depth), one route entry read and compared per cycle, bank 0 then 1
// transactions: one at a time, a request is accepted only in ST_IDLE,
//   a new one is taken while the last result waits
// reset clears the sequencer, handshake and count registers; route memories are not cleared
`default_nettype none

module two_bank_longest_prefix_match import tblpm_pkg::*; #(
	parameter int BANK0_DEPTH = 1024,
	parameter int BANK1_DEPTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tblpm_req_if.sink                  req,
	tblpm_rsp_if.source                rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW0  = (BANK0_DEPTH > 1) ? $clog2(BANK0_DEPTH) : 1;
	localparam int AW1  = (BANK1_DEPTH > 1) ? $clog2(BANK1_DEPTH) : 1;
	localparam int MAXD = (BANK0_DEPTH > BANK1_DEPTH) ? BANK0_DEPTH : BANK1_DEPTH;
	localparam int CW   = $clog2(MAXD + 1);
	localparam int IW   = (CW > 10) ? CW : 10;
	localparam int LW   = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	state_t                state_q;
	logic [CFG_DATA_W-1:0] count0_q, count1_q;
	logic [31:0]           dest_q;
	logic                  cur_bank_q;
	logic [CW-1:0]         idx_q;

	logic                  rd_v_s1;
	logic                  rd_bank_s1;
	logic [CW-1:0]         rd_idx_s1;
	route_t                rdata0_s1, rdata1_s1;

	logic                  hit_q;
	logic                  best_bank_q;
	logic [CW-1:0]         best_idx_q;
	logic [31:0]           best_mask_q;
	logic [31:0]           best_hop_q;
	logic [7:0]            best_port_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [31:0]           out_hop_q;
	logic [7:0]            out_port_q;
	logic [31:0]           out_mask_q;
	logic                  out_bank_q;
	logic [9:0]            out_idx_q;

	route_t                mem0 [BANK0_DEPTH];
	route_t                mem1 [BANK1_DEPTH];

	logic                  accept;
	logic [IW-1:0]         widx;
	logic                  wr0, wr1;
	route_t                wentry;
	logic [LW-1:0]         lim0_w, lim1_w;
	logic [CW-1:0]         lim;
	route_t                cand;
	logic                  match;
	logic                  take;
	logic                  out_free;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	// write decode, slots beyond the bank depth are dropped
	assign widx   = IW'(req.entry_index);
	assign wr0    = accept && (req.operation == OP_WRITE) && !req.bank
		&& (widx < IW'(BANK0_DEPTH));
	assign wr1    = accept && (req.operation == OP_WRITE) && req.bank
		&& (widx < IW'(BANK1_DEPTH));
	assign wentry = '{prefix: req.entry_prefix, mask: req.entry_mask,
		hop: req.entry_next_hop, port: req.entry_port};

	// scan limit per bank, count saturated at depth
	assign lim0_w = (LW'(count0_q) < LW'(BANK0_DEPTH)) ? LW'(count0_q) : LW'(BANK0_DEPTH);
	assign lim1_w = (LW'(count1_q) < LW'(BANK1_DEPTH)) ? LW'(count1_q) : LW'(BANK1_DEPTH);
	assign lim    = cur_bank_q ? lim1_w[CW-1:0] : lim0_w[CW-1:0];

	// shared compare unit
	assign cand  = rd_bank_s1 ? rdata1_s1 : rdata0_s1;
	assign match = (dest_q & cand.mask) == cand.prefix;
	assign take  = rd_v_s1 && match && (!hit_q || (best_mask_q < cand.mask)
		|| (rd_bank_s1 && !best_bank_q && (best_mask_q == cand.mask)));

	// route memories
	always_ff @(posedge clk) begin
		if (wr0) begin
			mem0[widx[AW0-1:0]] <= wentry;
		end
		if (wr1) begin
			mem1[widx[AW1-1:0]] <= wentry;
		end
		rdata0_s1 <= mem0[idx_q[AW0-1:0]];
		rdata1_s1 <= mem1[idx_q[AW1-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count0_q <= '0;
			count1_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BANK0_COUNT: count0_q <= cfg_data;
				CFG_BANK1_COUNT: count1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_v_s1    <= 1'b0;
			cur_bank_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (accept) begin
						cur_bank_q <= 1'b0;
						idx_q      <= '0;
						state_q    <= (req.operation == OP_LOOKUP) ? ST_SCAN : ST_LOAD;
					end
				end
				ST_SCAN: begin
					if (idx_q < lim) begin
						rd_v_s1 <= 1'b1;
						idx_q   <= idx_q + 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!cur_bank_q) begin
							cur_bank_q <= 1'b1;
							idx_q      <= '0;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rd_v_s1 <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rd_v_s1 <= 1'b0;
				end
			endcase
		end
	end

	// read tag and destination capture
	always_ff @(posedge clk) begin
		rd_bank_s1 <= cur_bank_q;
		rd_idx_s1  <= idx_q;
		if (accept) begin
			dest_q <= req.dest_addr;
		end
	end

	// best route so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (accept) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_bank_q <= rd_bank_s1;
			best_idx_q  <= rd_idx_s1;
			best_mask_q <= cand.mask;
			best_hop_q  <= cand.hop;
			best_port_q <= cand.port;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_LOAD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_LOAD) && out_free) begin
			out_found_q <= hit_q;
			out_hop_q   <= hit_q ? best_hop_q : '0;
			out_port_q  <= hit_q ? best_port_q : '0;
			out_mask_q  <= hit_q ? best_mask_q : '0;
			out_bank_q  <= hit_q ? best_bank_q : 1'b0;
			out_idx_q   <= hit_q ? 10'(best_idx_q) : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.found         = out_found_q;
	assign rsp.next_hop_out  = out_hop_q;
	assign rsp.port_out      = out_port_q;
	assign rsp.matched_mask  = out_mask_q;
	assign rsp.matched_bank  = out_bank_q;
	assign rsp.matched_index = out_idx_q;

endmodule

`default_nettype wire
